// File: src/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Types and constants shared by the Bezier point evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

   localparam int COORD_W        = 24;
   localparam int COUNT_W        = 3;
   localparam int T_W            = 13;
   localparam int T_SHIFT        = 12;
   localparam int T_ONE          = 4096;
   localparam int IN_POINTS      = 4;
   localparam int MAX_POINTS_DEF = 4;

   // b - a needs one extra bit; t is widened by a zero sign bit
   localparam int DIFF_W = COORD_W + 1;
   localparam int TS_W   = T_W + 1;
   localparam int PROD_W = DIFF_W + TS_W;
   localparam int Q_W    = PROD_W - T_SHIFT;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [T_W-1:0]            param_type;
   typedef logic [COUNT_W-1:0]        count_type;

   typedef struct packed {
      count_type point_count;
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p3_x;
      coord_type p3_y;
      param_type param_t;
   } req_type;

   typedef struct packed {
      coord_type curve_x;
      coord_type curve_y;
   } rsp_type;

   // control that travels with each beat down the pipeline
   typedef struct packed {
      logic      valid;
      count_type count;
   } ctl_type;

endpackage

`default_nettype wire

// File: src/bpe_level.sv
// ----------------------------------------------------------------------------
// bpe_level
// One de Casteljau level: multiply stage, then shift-and-add stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_level #(
   parameter int N_PTS = bpe_pkg::MAX_POINTS_DEF,
   parameter int LEVEL = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  bpe_pkg::ctl_type    ctl_in,
   input  bpe_pkg::param_type  t_in,
   input  bpe_pkg::coord_type  x_in  [N_PTS],
   input  bpe_pkg::coord_type  y_in  [N_PTS],
   output bpe_pkg::ctl_type    ctl_out,
   output bpe_pkg::param_type  t_out,
   output bpe_pkg::coord_type  x_out [N_PTS],
   output bpe_pkg::coord_type  y_out [N_PTS]
);

   localparam int NP = N_PTS - 1;

   // stage A: differences times t
   bpe_pkg::ctl_type                       ctl_a_ff;
   bpe_pkg::param_type                     t_a_ff;
   bpe_pkg::coord_type                     x_a_ff [N_PTS];
   bpe_pkg::coord_type                     y_a_ff [N_PTS];
   logic signed [bpe_pkg::PROD_W-1:0]      px_in  [NP];
   logic signed [bpe_pkg::PROD_W-1:0]      py_in  [NP];
   logic signed [bpe_pkg::PROD_W-1:0]      px_ff  [NP];
   logic signed [bpe_pkg::PROD_W-1:0]      py_ff  [NP];
   logic signed [bpe_pkg::TS_W-1:0]        t_sgn;

   // stage B: a + (prod >>> 12) where the pair is active at this level
   bpe_pkg::ctl_type                       ctl_b_ff;
   bpe_pkg::param_type                     t_b_ff;
   bpe_pkg::coord_type                     x_b_in [N_PTS];
   bpe_pkg::coord_type                     y_b_in [N_PTS];
   bpe_pkg::coord_type                     x_b_ff [N_PTS];
   bpe_pkg::coord_type                     y_b_ff [N_PTS];

   assign t_sgn = $signed({1'b0, t_in});

   always_comb begin
      logic signed [bpe_pkg::DIFF_W-1:0] dx;
      logic signed [bpe_pkg::DIFF_W-1:0] dy;
      for (int i = 0; i < NP; i++) begin
         dx       = bpe_pkg::DIFF_W'(x_in[i+1]) - bpe_pkg::DIFF_W'(x_in[i]);
         dy       = bpe_pkg::DIFF_W'(y_in[i+1]) - bpe_pkg::DIFF_W'(y_in[i]);
         px_in[i] = dx * t_sgn;
         py_in[i] = dy * t_sgn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
      end else begin
         ctl_a_ff.valid <= ctl_in.valid;
      end
      ctl_a_ff.count <= ctl_in.count;
      t_a_ff         <= t_in;
      x_a_ff         <= x_in;
      y_a_ff         <= y_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
   end

   always_comb begin
      logic signed [bpe_pkg::Q_W-1:0] qx;
      logic signed [bpe_pkg::Q_W-1:0] qy;
      x_b_in = x_a_ff;
      y_b_in = y_a_ff;
      for (int i = 0; i < NP; i++) begin
         // floor division by 4096 is the arithmetic shift
         qx = $signed(px_ff[i][bpe_pkg::PROD_W-1:bpe_pkg::T_SHIFT]);
         qy = $signed(py_ff[i][bpe_pkg::PROD_W-1:bpe_pkg::T_SHIFT]);
         if ((i + LEVEL + 1) < int'(ctl_a_ff.count)) begin
            x_b_in[i] = bpe_pkg::COORD_W'(bpe_pkg::Q_W'(x_a_ff[i]) + qx);
            y_b_in[i] = bpe_pkg::COORD_W'(bpe_pkg::Q_W'(y_a_ff[i]) + qy);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff.valid <= 1'b0;
      end else begin
         ctl_b_ff.valid <= ctl_a_ff.valid;
      end
      ctl_b_ff.count <= ctl_a_ff.count;
      t_b_ff         <= t_a_ff;
      x_b_ff         <= x_b_in;
      y_b_ff         <= y_b_in;
   end

   assign ctl_out = ctl_b_ff;
   assign t_out   = t_b_ff;
   assign x_out   = x_b_ff;
   assign y_out   = y_b_ff;

endmodule

`default_nettype wire

// File: src/bezier_point_evaluator_core.sv
// ----------------------------------------------------------------------------
// bezier_point_evaluator_core
// Pipelined de Casteljau evaluation of a Bezier curve of up to cubic degree.
// ----------------------------------------------------------------------------
// One beat is taken on every clock where start is high; busy is always low.
// The result of each beat appears on rsp_data with rsp_strobe high for one
// cycle. Each beat passes through an input register, then through each of the
// P-1 interpolation levels, where P is the lesser of MAX_POINTS and four; each
// level is a multiply stage and a shift-and-add stage. An output register
// follows the last level. There is no back-pressure: the receiver must take
// every result on its strobe cycle.
`default_nettype none

module bezier_point_evaluator_core #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bpe_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bpe_pkg::rsp_type rsp_data
);

   localparam int LIMIT   = (MAX_POINTS < bpe_pkg::IN_POINTS) ? MAX_POINTS
                                                              : bpe_pkg::IN_POINTS;
   localparam int LEVELS  = LIMIT - 1;
   localparam int LATENCY = 2 * LEVELS + 2;

   bpe_pkg::ctl_type   ctl_chain [LEVELS+1];
   bpe_pkg::param_type t_chain   [LEVELS+1];
   bpe_pkg::coord_type x_chain   [LEVELS+1][LIMIT];
   bpe_pkg::coord_type y_chain   [LEVELS+1][LIMIT];

   bpe_pkg::ctl_type   ctl_in;
   bpe_pkg::param_type t_in;
   bpe_pkg::coord_type x_in [bpe_pkg::IN_POINTS];
   bpe_pkg::coord_type y_in [bpe_pkg::IN_POINTS];
   bpe_pkg::ctl_type   ctl_ff;
   bpe_pkg::param_type t_ff;
   bpe_pkg::coord_type x_ff [LIMIT];
   bpe_pkg::coord_type y_ff [LIMIT];

   logic               rsp_strobe_ff;
   bpe_pkg::rsp_type   rsp_data_ff;

   assign busy = 1'b0;

   // clamp count to 1..LIMIT and t to one
   always_comb begin
      ctl_in.valid = start;
      if (req_data.point_count > bpe_pkg::COUNT_W'(LIMIT)) begin
         ctl_in.count = bpe_pkg::COUNT_W'(LIMIT);
      end else if (req_data.point_count == '0) begin
         ctl_in.count = bpe_pkg::COUNT_W'(1);
      end else begin
         ctl_in.count = req_data.point_count;
      end
      if (req_data.param_t > bpe_pkg::T_W'(bpe_pkg::T_ONE)) begin
         t_in = bpe_pkg::T_W'(bpe_pkg::T_ONE);
      end else begin
         t_in = req_data.param_t;
      end
      x_in[0] = req_data.p0_x;
      y_in[0] = req_data.p0_y;
      x_in[1] = req_data.p1_x;
      y_in[1] = req_data.p1_y;
      x_in[2] = req_data.p2_x;
      y_in[2] = req_data.p2_y;
      x_in[3] = req_data.p3_x;
      y_in[3] = req_data.p3_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.count <= ctl_in.count;
      t_ff         <= t_in;
      for (int i = 0; i < LIMIT; i++) begin
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
      end
   end

   assign ctl_chain[0] = ctl_ff;
   assign t_chain[0]   = t_ff;
   assign x_chain[0]   = x_ff;
   assign y_chain[0]   = y_ff;

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      bpe_level #(
         .N_PTS (LIMIT),
         .LEVEL (k)
      ) u_level (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_chain[k]),
         .t_in    (t_chain[k]),
         .x_in    (x_chain[k]),
         .y_in    (y_chain[k]),
         .ctl_out (ctl_chain[k+1]),
         .t_out   (t_chain[k+1]),
         .x_out   (x_chain[k+1]),
         .y_out   (y_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctl_chain[LEVELS].valid;
      end
      rsp_data_ff.curve_x <= x_chain[LEVELS][0];
      rsp_data_ff.curve_y <= y_chain[LEVELS][0];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // every accepted beat produces a result strobe
   a_beat_out : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_strobe)
      else $error("accepted beat did not produce a result");

   // no result without a matching accepted beat
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without matching beat");

   // at t of zero the curve point is the first control point
   a_t_zero : assert property (@(posedge clock) disable iff (reset)
      (start && req_data.param_t == '0) |-> ##LATENCY
         (rsp_data.curve_x == $past(req_data.p0_x, LATENCY) &&
          rsp_data.curve_y == $past(req_data.p0_y, LATENCY)))
      else $error("t of zero did not return first point");

endmodule

`default_nettype wire
